>>> rtl/sha256_pkg.sv
// Package with SHA-256 constants, round constant lookup and shared types.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS = 7'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic has_byte;
    logic end_of_message;
  } in_item_t;

  typedef struct packed {
    word_t digest_word;
    logic [2:0] word_index;
    logic last_word;
  } out_item_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/sha256_stream_if.sv
// Valid/ready stream interface carrying one item of a given payload type.
`timescale 1ns / 1ps
interface sha256_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/sha256_stream_hasher.sv
// Top level: SHA-256 hasher over a byte stream with a shared round unit.
//
// Input items carry one message byte (when has_byte is set) and an end flag.
// A byte is written to the block buffer as it is accepted; in_ready then drops
// for one cycle while the byte is settled. The 64th byte of a block starts
// compression: each buffer word is loaded as an address, then registered read
// data, then one round per cycle through a single round unit with the message
// schedule kept in a 16-word rolling window, 64 rounds plus a chain-add step.
// An end item triggers padding: the pad and zero fill are written one byte
// per cycle into the buffer, then the length, then one or two compressions.
// The digest follows as eight items, word 0 first, last_word on word 7.
// The result register holds a word until out_ready takes it; the block
// waits and accepts nothing while digest words are pending.
// After the last word the chain words and counts return to their initial
// values and a new message may start. Synchronous active-low reset restores
// the initial hash values and empty counts; no clearing pass is needed.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input logic clk,
  input logic rst_n,
  sha256_stream_if.sink in_ch,
  sha256_stream_if.source out_ch
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD = 3'd3;
  localparam logic [2:0] S_PAD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_SETTLE = 3'd6;

  logic [2:0] state_r, state_nxt;
  word_t chain_r [8];
  word_t v_r [8];
  word_t w_r [16];
  word_t buf_mem [16];
  logic [5:0] cnt_r;
  logic [60:0] msg_cnt_r;
  logic [6:0] rnd_r;
  logic [6:0] pad_idx_r;
  logic final_r;
  logic pend_end_r;
  logic [3:0] load_r;
  logic [2:0] oidx_r;
  logic ovalid_r;
  word_t odata_r;
  word_t rd_word_r;
  logic [63:0] bits;
  word_t t1, t2, wnew, s0, s1, wcur;
  logic in_fire, out_fire;
  logic [7:0] pad_byte;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload.digest_word = odata_r;
  assign out_ch.payload.word_index = oidx_r;
  assign out_ch.payload.last_word = (oidx_r == 3'd7);
  assign bits = {msg_cnt_r, 3'b000};

  always_comb begin
    if (final_r && pad_idx_r >= LEN_POS) begin
      pad_byte = bits[8'(7'd63 - pad_idx_r) * 8 +: 8];
    end else if (pad_idx_r[5:0] == cnt_r) begin
      pad_byte = PAD_BYTE;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Message schedule and round datapath, shared across all rounds.
  assign wcur = w_r[0];
  assign s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = s1 + w_r[9] + s0 + w_r[0];
  assign t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25)) +
              ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K[rnd_r[5:0]] + wcur;
  assign t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22)) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire && in_ch.payload.has_byte) begin
      buf_mem[cnt_r[5:2]][{~cnt_r[1:0], 3'b000} +: 8] <= in_ch.payload.data_byte;
    end else if (state_r == S_PAD) begin
      buf_mem[pad_idx_r[5:2]][{~pad_idx_r[1:0], 3'b000} +: 8] <= pad_byte;
    end
    rd_word_r <= buf_mem[load_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.payload.has_byte && cnt_r == 6'd63) begin
            state_nxt = S_LOAD;
          end else if (in_ch.payload.end_of_message) begin
            state_nxt = S_PAD;
          end else if (in_ch.payload.has_byte) begin
            state_nxt = S_SETTLE;
          end
        end
      end
      S_SETTLE: state_nxt = S_IDLE;
      S_LOAD: if (load_r == 4'd15 && rnd_r[0]) state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 7'd63) state_nxt = S_ADD;
      S_ADD: begin
        if (final_r) state_nxt = S_OUT;
        else if (pend_end_r) state_nxt = S_PAD;
        else state_nxt = S_IDLE;
      end
      S_PAD: if (pad_idx_r == 7'd63) state_nxt = S_LOAD;
      S_OUT: if (out_fire && oidx_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 8; i++) chain_r[i] <= H0[i];
      cnt_r <= '0;
      msg_cnt_r <= '0;
      rnd_r <= '0;
      pad_idx_r <= '0;
      final_r <= 1'b0;
      pend_end_r <= 1'b0;
      load_r <= '0;
      oidx_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.payload.has_byte) begin
              cnt_r <= cnt_r + 6'd1;
              msg_cnt_r <= msg_cnt_r + 61'd1;
            end
            pend_end_r <= in_ch.payload.end_of_message;
            load_r <= '0;
            rnd_r <= '0;
            final_r <= 1'b0;
            if (in_ch.payload.end_of_message &&
                !(in_ch.payload.has_byte && cnt_r == 6'd63)) begin
              pad_idx_r <= {1'b0, cnt_r} + {6'd0, in_ch.payload.has_byte};
              if ({1'b0, cnt_r} + {6'd0, in_ch.payload.has_byte} < LEN_POS)
                final_r <= 1'b1;
            end
          end
        end
        S_SETTLE: begin
        end
        S_LOAD: begin
          // Each word: the address first, then the registered read data.
          rnd_r[0] <= ~rnd_r[0];
          if (rnd_r[0]) begin
            w_r[load_r] <= rd_word_r;
            load_r <= load_r + 4'd1;
          end
          if (load_r == 4'd15 && rnd_r[0]) begin
            rnd_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 7'd1;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
          if (final_r) begin
            odata_r <= chain_r[0] + v_r[0];
            oidx_r <= '0;
            ovalid_r <= 1'b1;
          end else if (pend_end_r) begin
            // The final block still follows: it starts from a fresh buffer.
            pad_idx_r <= '0;
            final_r <= 1'b1;
          end
        end
        S_PAD: begin
          pad_idx_r <= pad_idx_r + 7'd1;
          load_r <= '0;
          rnd_r <= '0;
          if (pad_idx_r == 7'd63) begin
            pend_end_r <= 1'b1;
            if (final_r) begin
              cnt_r <= '0;
            end else begin
              cnt_r <= 6'd63;
            end
          end
        end
        S_OUT: begin
          if (out_fire) begin
            if (oidx_r == 3'd7) begin
              ovalid_r <= 1'b0;
              for (int i = 0; i < 8; i++) chain_r[i] <= H0[i];
              cnt_r <= '0;
              msg_cnt_r <= '0;
              final_r <= 1'b0;
              pend_end_r <= 1'b0;
            end else begin
              oidx_r <= oidx_r + 3'd1;
              odata_r <= chain_r[oidx_r + 3'd1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // In the second padding block the pad byte sits before the buffer start,
  // so the pad index compare must not match: cnt_r is parked at 63 then and
  // the length bytes take precedence in that slot.

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (state_r == S_OUT)) else $error("output outside digest phase");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && oidx_r == 3'd7) |=> !out_ch.valid) else $error("extra digest word");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r < 7'd64)) else $error("round overrun");
`endif

endmodule

>>> sim/sha256_stream_hasher_tb.sv
// SHA-256 stream hasher testbench: directed and random messages checked by a built-in digest model.
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
  import sha256_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha256_stream_if #(.payload_t(in_item_t)) in_ch (clk);
  sha256_stream_if #(.payload_t(out_item_t)) out_ch (clk);

  sha256_stream_hasher dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  localparam int IDLE_LIMIT = 20000;

  in_item_t pending_items[$];
  out_item_t expected_words[$];
  word_t hash_state[8];
  logic [7:0] msg_block[64];
  int unsigned block_fill;
  logic [60:0] byte_total;
  int fail_count = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit pause_sender = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t w[64];
    word_t v[8];
    word_t t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function automatic void restart_message();
    hash_state = H0;
    block_fill = 0;
    byte_total = '0;
  endfunction

  function automatic void hash_item(in_item_t it);
    logic [63:0] bit_len;
    int unsigned i;
    out_item_t o;
    if (it.has_byte) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      byte_total++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    bit_len = {byte_total, 3'b000};
    i = block_fill;
    msg_block[i] = PAD_BYTE;
    i++;
    if (i > LEN_POS) begin
      while (i < 64) begin msg_block[i] = 8'h00; i++; end
      compress_block();
      i = 0;
    end
    while (i < LEN_POS) begin msg_block[i] = 8'h00; i++; end
    for (int k = 0; k < 8; k++) msg_block[56 + k] = bit_len[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_state[k];
      o.word_index = 3'(k);
      o.last_word = (k == 7);
      expected_words.push_back(o);
    end
    restart_message();
  endfunction

  function automatic in_item_t make_item(logic [7:0] b, logic h, logic e);
    in_item_t it;
    it.data_byte = b;
    it.has_byte = h;
    it.end_of_message = e;
    return it;
  endfunction

  task automatic queue_message(int len, bit end_with_byte, int pattern);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      if (($urandom_range(0, 15) == 0))
        pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b0));
      pending_items.push_back(make_item(b, 1'b1, end_with_byte && (i == len - 1)));
    end
    if (!end_with_byte || len == 0)
      pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b1));
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic bit send_gap_next_nonzero();
    return $urandom_range(0, 3) == 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hash_item(in_ch.payload);
        send_gap <= pick_gap();
      end
      if ((in_ch.valid && !in_ch.ready)) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0 && !(in_ch.valid && in_ch.ready)) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0 && !pause_sender &&
                   !(in_ch.valid && in_ch.ready && send_gap_next_nonzero())) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest item %h", out_ch.payload);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.payload.digest_word !== exp_w.digest_word) begin
            $error("digest_word expected %h actual %h", exp_w.digest_word,
                   out_ch.payload.digest_word);
            fail_count++;
          end
          if (out_ch.payload.word_index !== exp_w.word_index) begin
            $error("word_index expected %0d actual %0d", exp_w.word_index,
                   out_ch.payload.word_index);
            fail_count++;
          end
          if (out_ch.payload.last_word !== exp_w.last_word) begin
            $error("last_word expected %0d actual %0d", exp_w.last_word,
                   out_ch.payload.last_word);
            fail_count++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready) recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sha256_stream_hasher test failed");
      $finish;
    end
  end

  initial begin
    int lens[$];
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    restart_message();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, padding boundaries, extreme bytes, ignored items.
    pending_items.push_back(make_item(8'hff, 1'b0, 1'b0));
    queue_message(0, 1'b0, 2);
    queue_message(3, 1'b1, 2);
    queue_message(1, 1'b1, 1);
    queue_message(2, 1'b0, 0);
    lens = {55, 56, 63, 64, 65};
    foreach (lens[i]) queue_message(lens[i], bit'(i % 2), (i < 2) ? i : 2);

    // Receiver holds off so the digest output backs up while bytes keep coming.
    wait (pending_items.size() < 300);
    hold_off = 400;
    wait (pending_items.size() == 0);
    pause_sender = 1'b1;
    wait (expected_words.size() == 0 && !in_ch.valid);
    repeat (20) @(posedge clk);
    pause_sender = 1'b0;

    // Random messages, mostly short, a few filling a whole block.
    while (pending_items.size() < 40) begin
      if ($urandom_range(0, 9) == 0)
        queue_message($urandom_range(60, 70), $urandom_range(0, 1), 2);
      else
        queue_message($urandom_range(0, 12), $urandom_range(0, 1), 2);
    end
    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_words.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0)
      $display("sha256_stream_hasher test passed");
    else
      $display("sha256_stream_hasher test failed");
    $finish;
  end
endmodule
